@@ design/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared widths, types and arithmetic helpers of the light scissor rectangle
// block.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int RAD_W     = 31;
  localparam int COORD_W   = IN_W + 1;
  localparam int ENT_W     = 32;
  localparam int PROD_W    = ENT_W + COORD_W;
  localparam int SH_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SH_W + 2;
  localparam int REM_W     = SUM_W + 1;
  localparam int Q_BITS    = 15;
  localparam int SCR_W     = 17;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int NUM_ROWS  = 3;
  localparam int NUM_AXES  = 3;
  localparam int CORNER_W  = 3;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_W = 2;

  localparam logic [SCR_W-1:0] SCR_ONE  = SCR_W'(65536);
  localparam logic [SCR_W-1:0] SCR_HALF = SCR_W'(32768);
  localparam logic [SCR_W-1:0] SCR_ZERO = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XROW_LO,
    REG_XROW_HI,
    REG_YROW_LO,
    REG_YROW_HI,
    REG_WROW_LO,
    REG_WROW_HI
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // Per-corner control that travels with the data
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  // One screen axis inside the divider
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [Q_BITS-1:0] q;
    logic              neg;
    logic              sat_hi;
    logic              sat_lo;
  } lane_t;

  typedef struct packed {
    tag_t             tag;
    logic             behind;
    logic [SUM_W-1:0] w;
    lane_t            lx;
    lane_t            ly;
  } div_stage_t;

  // Classify v against w and load the magnitude for division
  function automatic lane_t lane_setup(sum_t v, sum_t w);
    lane_t            l;
    logic [SUM_W-1:0] mag;
    l.sat_hi = (v >= w);
    l.sat_lo = !l.sat_hi && (v <= -w);
    l.neg    = v[SUM_W-1];
    mag      = l.neg ? SUM_W'(-v) : SUM_W'(v);
    l.rem    = {1'b0, mag};
    l.q      = '0;
    return l;
  endfunction

  // One restoring division step: one quotient bit
  function automatic lane_t div_step(lane_t l, logic [SUM_W-1:0] w);
    lane_t            o;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] wz;
    o    = l;
    rem2 = {l.rem[REM_W-2:0], 1'b0};
    wz   = {1'b0, w};
    if (rem2 >= wz) begin
      o.rem = rem2 - wz;
      o.q   = {l.q[Q_BITS-2:0], 1'b1};
    end else begin
      o.rem = rem2;
      o.q   = {l.q[Q_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  // Map the finished quotient to the screen coordinate
  function automatic logic [SCR_W-1:0] lane_screen(lane_t l);
    logic [SCR_W-1:0] qz;
    qz = SCR_W'(l.q);
    if (l.sat_hi) return SCR_ONE;
    if (l.sat_lo) return SCR_ZERO;
    return l.neg ? SCR_HALF - qz : SCR_HALF + qz;
  endfunction

endpackage

@@ design/ssr_if.sv @@
// ----------------------------------------------------------------------------
// ssr_if
// Valid/ready channels of the light scissor rectangle block.
// ----------------------------------------------------------------------------
interface ssr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ssr_pkg::IN_W-1:0]       center_x;
  logic signed [ssr_pkg::IN_W-1:0]       center_y;
  logic signed [ssr_pkg::IN_W-1:0]       center_z;
  logic        [ssr_pkg::RAD_W-1:0]      radius;
  modport source (output valid, center_x, center_y, center_z, radius, input ready);
  modport sink   (input valid, center_x, center_y, center_z, radius, output ready);
endinterface

interface ssr_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssr_pkg::SCR_W-1:0]     rect_min_x;
  logic [ssr_pkg::SCR_W-1:0]     rect_min_y;
  logic [ssr_pkg::SCR_W-1:0]     rect_max_x;
  logic [ssr_pkg::SCR_W-1:0]     rect_max_y;
  logic                          behind_eye;
  modport source (output valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                  behind_eye, input ready);
  modport sink   (input valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                  behind_eye, output ready);
endinterface

@@ design/ssr_corner_gen.sv @@
// ----------------------------------------------------------------------------
// ssr_corner_gen
// Holds a light; issues its eight cube corners, one per enabled cycle.
// ----------------------------------------------------------------------------
module ssr_corner_gen (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  ssr_in_if.sink                            in_ch,
  output ssr_pkg::tag_t                     tag_o,
  output ssr_pkg::coord_t                   v_o [ssr_pkg::NUM_AXES]
);
  import ssr_pkg::*;

  logic signed [IN_W-1:0] cen_r [NUM_AXES];
  logic [RAD_W-1:0]       rad_r;
  logic [CORNER_W-1:0]    cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   last_corner;
  logic                   accept;
  tag_t                   tag_r;
  coord_t                 v_r [NUM_AXES];

  assign last_corner = (cnt_r == {CORNER_W{1'b1}});
  assign in_ch.ready = !busy_r || (en && last_corner);
  assign accept      = in_ch.valid && in_ch.ready;

  // Advance the corner count; take the next light on the last corner
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r && en) begin
      cnt_nxt = cnt_r + CORNER_W'(1);
      if (last_corner) busy_nxt = 1'b0;
    end
    if (accept) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      tag_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      if (en) begin
        tag_r.valid <= busy_r;
        tag_r.first <= (cnt_r == '0);
        tag_r.last  <= last_corner;
      end
    end
  end

  // Hold the light; form centre +/- radius per axis
  always_ff @(posedge clk) begin
    if (accept) begin
      cen_r[0] <= in_ch.center_x;
      cen_r[1] <= in_ch.center_y;
      cen_r[2] <= in_ch.center_z;
      rad_r    <= in_ch.radius;
    end
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (cnt_r[NUM_AXES-1-a])
          v_r[a] <= COORD_W'(cen_r[a]) + coord_t'({2'b00, rad_r});
        else
          v_r[a] <= COORD_W'(cen_r[a]) - coord_t'({2'b00, rad_r});
      end
    end
  end

  assign tag_o = tag_r;
  assign v_o   = v_r;

endmodule

@@ design/ssr_transform.sv @@
// ----------------------------------------------------------------------------
// ssr_transform
// Matrix registers and the x, y, w row products, sums and range checks.
// ----------------------------------------------------------------------------
module ssr_transform (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]         cfg_wdata,
  input  ssr_pkg::tag_t                     tag_i,
  input  ssr_pkg::coord_t                   v_i [ssr_pkg::NUM_AXES],
  output ssr_pkg::div_stage_t               stage_o
);
  import ssr_pkg::*;

  logic [CFG_W-1:0]        regs_r [NUM_REGS];
  logic signed [ENT_W-1:0] ent   [NUM_ROWS][NUM_AXES+1];
  logic signed [PROD_W-1:0] prod [NUM_ROWS][NUM_AXES];
  logic signed [SH_W-1:0]  prod_r [NUM_ROWS][NUM_AXES];
  sum_t                    sum_r  [NUM_ROWS];
  tag_t                    tag1_r, tag2_r;
  div_stage_t              stage_r;

  // Write matrix registers; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_we && (cfg_index <= REG_WROW_HI)) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  // Unpack entries: low word even, high word odd
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < NUM_AXES + 1; k++) begin
        if (k % 2 == 1) ent[r][k] = regs_r[r*2 + k/2][CFG_W-1:ENT_W];
        else            ent[r][k] = regs_r[r*2 + k/2][ENT_W-1:0];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++)
      for (int k = 0; k < NUM_AXES; k++)
        prod[r][k] = PROD_W'(ent[r][k]) * PROD_W'(v_i[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r  <= '0;
      tag2_r  <= '0;
      stage_r <= '0;
    end else if (en) begin
      tag1_r            <= tag_i;
      tag2_r            <= tag1_r;
      stage_r.tag       <= tag2_r;
      stage_r.behind    <= (sum_r[ROW_W] <= 0);
      stage_r.w         <= sum_r[ROW_W];
      stage_r.lx        <= lane_setup(sum_r[ROW_X], sum_r[ROW_W]);
      stage_r.ly        <= lane_setup(sum_r[ROW_Y], sum_r[ROW_W]);
    end
  end

  // Floor each product to the fixed-point grid, then add the row terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < NUM_AXES; k++)
          prod_r[r][k] <= SH_W'(prod[r][k] >>> FRAC_BITS);
        sum_r[r] <= SUM_W'(ent[r][NUM_AXES]) + SUM_W'(prod_r[r][0])
                  + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2]);
      end
    end
  end

  assign stage_o = stage_r;

endmodule

@@ design/ssr_divider.sv @@
// ----------------------------------------------------------------------------
// ssr_divider
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
// ----------------------------------------------------------------------------
module ssr_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ssr_pkg::div_stage_t  stage_i,
  output ssr_pkg::div_stage_t  stage_o
);
  import ssr_pkg::*;

  div_stage_t st_r [Q_BITS];
  div_stage_t prev [Q_BITS];

  always_comb begin
    prev[0] = stage_i;
    for (int i = 1; i < Q_BITS; i++) prev[i] = st_r[i-1];
  end

  // Advance each stage by one quotient bit; clear only the tags on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Q_BITS; i++) st_r[i].tag <= '0;
    end else if (en) begin
      for (int i = 0; i < Q_BITS; i++) begin
        st_r[i].tag    <= prev[i].tag;
        st_r[i].behind <= prev[i].behind;
        st_r[i].w      <= prev[i].w;
        st_r[i].lx     <= div_step(prev[i].lx, prev[i].w);
        st_r[i].ly     <= div_step(prev[i].ly, prev[i].w);
      end
    end
  end

  assign stage_o = st_r[Q_BITS-1];

endmodule

@@ design/ssr_accum.sv @@
// ----------------------------------------------------------------------------
// ssr_accum
// Running min/max over the corners of a light and the result register.
// ----------------------------------------------------------------------------
module ssr_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssr_pkg::div_stage_t  stage_i,
  output logic                 en,
  ssr_out_if.source            out_ch
);
  import ssr_pkg::*;

  logic [SCR_W-1:0] minx_r, miny_r, maxx_r, maxy_r;
  logic             beh_r;
  logic [SCR_W-1:0] minx, miny, maxx, maxy, sx, sy;
  logic             beh;
  logic             out_valid_r, out_valid_nxt;
  logic [SCR_W-1:0] o_minx_r, o_miny_r, o_maxx_r, o_maxy_r;
  logic             o_beh_r;
  logic             take;

  assign en   = !out_valid_r || out_ch.ready;
  assign take = en && stage_i.tag.valid;
  assign sx   = lane_screen(stage_i.lx);
  assign sy   = lane_screen(stage_i.ly);

  // Fold this corner into the running box; restart on the first corner
  always_comb begin
    minx = stage_i.tag.first ? SCR_ONE  : minx_r;
    miny = stage_i.tag.first ? SCR_ONE  : miny_r;
    maxx = stage_i.tag.first ? SCR_ZERO : maxx_r;
    maxy = stage_i.tag.first ? SCR_ZERO : maxy_r;
    beh  = stage_i.tag.first ? 1'b0     : beh_r;
    if (stage_i.behind) begin
      beh = 1'b1;
    end else begin
      if (sx < minx) minx = sx;
      if (sx > maxx) maxx = sx;
      if (sy < miny) miny = sy;
      if (sy > maxy) maxy = sy;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (take && stage_i.tag.last) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      minx_r <= minx;
      miny_r <= miny;
      maxx_r <= maxx;
      maxy_r <= maxy;
      beh_r  <= beh;
      if (stage_i.tag.last) begin
        o_minx_r <= minx;
        o_miny_r <= miny;
        o_maxx_r <= maxx;
        o_maxy_r <= maxy;
        o_beh_r  <= beh;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.rect_min_x = o_minx_r;
  assign out_ch.rect_min_y = o_miny_r;
  assign out_ch.rect_max_x = o_maxx_r;
  assign out_ch.rect_max_y = o_maxy_r;
  assign out_ch.behind_eye = o_beh_r;

`ifndef ASSERT_OFF
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    stage_i.tag.valid |-> !(stage_i.tag.first && stage_i.tag.last))
    else $error("corner tagged both first and last");
  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stage_i.tag.last) |=> out_valid_r)
    else $error("last corner did not load a result");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_minx_r <= SCR_ONE && o_maxx_r <= SCR_ONE &&
                     o_miny_r <= SCR_ONE && o_maxy_r <= SCR_ONE))
    else $error("result edge outside the unit range");
`endif

endmodule

@@ design/sphere_screen_rect_core.sv @@
// A new light is accepted as the last corner of the previous one issues.
// The corner sequencer issues one cube corner per cycle, unless the output
// stalls, into a single shared transform and divide pipeline.
// Reset: synchronous active-low rst_n clears the matrix registers to zero,
// all valid bits and the corner sequencer; no clearing pass is needed.
// ----------------------------------------------------------------------------
// sphere_screen_rect_core
// Screen-space scissor rectangle of a light's cube from eight projected corners.
// ----------------------------------------------------------------------------
module sphere_screen_rect_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]      cfg_wdata,
  ssr_in_if.sink                         in_ch,
  ssr_out_if.source                      out_ch
);
  import ssr_pkg::*;

  logic       en;
  tag_t       tag0;
  coord_t     v0 [NUM_AXES];
  div_stage_t div_in, div_out;

  ssr_corner_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_ch (in_ch),
    .tag_o (tag0),
    .v_o   (v0)
  );

  ssr_transform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tag_i     (tag0),
    .v_i       (v0),
    .stage_o   (div_in)
  );

  ssr_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .stage_i (div_in),
    .stage_o (div_out)
  );

  ssr_accum u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage_i (div_out),
    .en      (en),
    .out_ch  (out_ch)
  );

endmodule
